FILE: rtl/are_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// are_pkg
// Types and constants shared by the ARP resolution engine modules.
// ----------------------------------------------------------------------------
package are_pkg;

  localparam int IP_W  = 32;
  localparam int MAC_W = 48;
  localparam int TTL_W = 24;
  localparam int ID_W  = 16;

  localparam logic [MAC_W-1:0] MAC_BCAST      = {MAC_W{1'b1}};
  localparam logic [TTL_W-1:0] LIFETIME_RESET = 24'd30000;
  localparam logic [TTL_W-1:0] HOLDOFF_RESET  = 24'd5000;
  localparam logic [15:0]      ETH_IPV4       = 16'h0800;
  localparam logic [15:0]      ETH_ARP        = 16'h0806;
  localparam logic [15:0]      ARP_OP_REQUEST = 16'd1;

  localparam logic [1:0] CMD_SEND = 2'd0;
  localparam logic [1:0] CMD_RECV = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [2:0] KIND_IPV4    = 3'd0;
  localparam logic [2:0] KIND_REQUEST = 3'd1;
  localparam logic [2:0] KIND_REPLY   = 3'd2;
  localparam logic [2:0] KIND_DELIVER = 3'd3;
  localparam logic [2:0] KIND_DROPPED = 3'd4;

  localparam logic [1:0] REG_OWN_MAC  = 2'd0;
  localparam logic [1:0] REG_OWN_IP   = 2'd1;
  localparam logic [1:0] REG_LIFETIME = 2'd2;
  localparam logic [1:0] REG_HOLDOFF  = 2'd3;

  typedef struct packed {
    logic [1:0]       command;
    logic [IP_W-1:0]  hop_ip;
    logic [ID_W-1:0]  datagram_id;
    logic [MAC_W-1:0] frame_dst_mac;
    logic [15:0]      frame_ether_type;
    logic             payload_ok;
    logic [15:0]      arp_opcode;
    logic [IP_W-1:0]  arp_sender_ip;
    logic [MAC_W-1:0] arp_sender_mac;
    logic [IP_W-1:0]  arp_target_ip;
    logic [TTL_W-1:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [MAC_W-1:0] dst_mac;
    logic [ID_W-1:0]  out_datagram_id;
    logic [IP_W-1:0]  arp_target_ip_out;
    logic [MAC_W-1:0] arp_target_mac_out;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic wr;
    logic clr;
    logic age;
  } ttl_ctrl_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic take_head;
  } wait_ctrl_t;

endpackage

FILE: rtl/are_ttl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// are_ttl_cell
// One entry of a timed table: key, time to live, valid, key compare, aging.
// ----------------------------------------------------------------------------
module are_ttl_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  are_pkg::ttl_ctrl_t      ctrl,
  input  logic [are_pkg::IP_W-1:0]  key_in,
  input  logic [are_pkg::TTL_W-1:0] ttl_in,
  input  logic [are_pkg::IP_W-1:0]  cmp_key,
  input  logic [are_pkg::TTL_W-1:0] elapsed,
  output logic                    valid,
  output logic                    match,
  output logic [are_pkg::TTL_W-1:0] ttl
);
  import are_pkg::*;

  logic [IP_W-1:0] key;

  assign match = valid && (key == cmp_key);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.wr) begin
      valid <= 1'b1;
    end else if (ctrl.clr && match) begin
      valid <= 1'b0;
    end else if (ctrl.age && valid && ttl <= elapsed) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      key <= key_in;
      ttl <= ttl_in;
    end else if (ctrl.age && valid && ttl > elapsed) begin
      ttl <= ttl - elapsed;
    end
  end

endmodule

FILE: rtl/are_wait_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// are_wait_cell
// One slot of the parked-datagram chain; shifts toward the head on rotate.
// ----------------------------------------------------------------------------
module are_wait_cell (
  input  logic                     clk,
  input  are_pkg::wait_ctrl_t      ctrl,
  input  logic [are_pkg::IP_W-1:0] push_ip,
  input  logic [are_pkg::ID_W-1:0] push_hdl,
  input  logic [are_pkg::IP_W-1:0] next_ip,
  input  logic [are_pkg::ID_W-1:0] next_hdl,
  input  logic [are_pkg::IP_W-1:0] head_ip,
  input  logic [are_pkg::ID_W-1:0] head_hdl,
  input  logic [are_pkg::IP_W-1:0] cmp_key,
  output logic [are_pkg::IP_W-1:0] ip,
  output logic [are_pkg::ID_W-1:0] hdl,
  output logic                     match
);
  import are_pkg::*;

  assign match = (ip == cmp_key);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      ip  <= push_ip;
      hdl <= push_hdl;
    end else if (ctrl.shift) begin
      // tail of the live chain takes the head back, the rest take the neighbor
      if (ctrl.take_head) begin
        ip  <= head_ip;
        hdl <= head_hdl;
      end else begin
        ip  <= next_ip;
        hdl <= next_hdl;
      end
    end
  end

endmodule

FILE: rtl/arp_resolution_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_resolution_engine
// ARP cache lookup, request issue, parked-datagram flush and reply.
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// in       in   in_valid/in_stall   in_data   (are_pkg::in_item_t)
// out      out  out_valid/out_stall out_data  (are_pkg::out_item_t)
// cfg      in   APB psel/penable    paddr[4:0], pwdata/prdata 64 bits
//
// One item at a time. Send: cache lookup, else park and request unless one
// is pending (sequential min-ttl scan when the pending table is full). ARP
// frame: learn (full cache scan when no slot is free), wait chain rotation
// over the parked datagrams, then a reply if due. Tick ages both tables.
// Results pass through the output register; out_stall holds the sequencer.
// Reset is synchronous and clears valid bits and counters; no clearing pass.
// ----------------------------------------------------------------------------
module arp_resolution_engine #(
  parameter int CACHE_ENTRIES   = 16,
  parameter int PENDING_ENTRIES = 8,
  parameter int WAIT_ENTRIES    = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  are_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output are_pkg::out_item_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);
  import are_pkg::*;

  localparam int CW = $clog2(CACHE_ENTRIES > 1 ? CACHE_ENTRIES : 2);
  localparam int PW = $clog2(PENDING_ENTRIES > 1 ? PENDING_ENTRIES : 2);
  localparam int SW = CW > PW ? CW : PW;
  localparam int NW = $clog2(WAIT_ENTRIES + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SEND  = 4'd1;
  localparam logic [3:0] S_PREQ  = 4'd2;
  localparam logic [3:0] S_RX    = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_LEARN = 4'd5;
  localparam logic [3:0] S_FLUSH = 4'd6;
  localparam logic [3:0] S_REPLY = 4'd7;
  localparam logic [3:0] S_TICK  = 4'd8;

  logic [3:0]       state;
  in_item_t         item;
  logic [MAC_W-1:0] own_mac;
  logic [IP_W-1:0]  own_ip;
  logic [TTL_W-1:0] lifetime;
  logic [TTL_W-1:0] holdoff;

  logic [SW-1:0]    slot;
  logic [SW-1:0]    scan_idx;
  logic [SW-1:0]    best_idx;
  logic [TTL_W-1:0] best_ttl;
  logic             scan_cache;
  logic [NW-1:0]    wait_count;
  logic [NW-1:0]    iter;
  logic [NW-1:0]    match_cnt;
  logic             reply;

  // ---------------- configuration ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac  <= '0;
      own_ip   <= '0;
      lifetime <= LIFETIME_RESET;
      holdoff  <= HOLDOFF_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:3])
        REG_OWN_MAC:  own_mac  <= pwdata[MAC_W-1:0];
        REG_OWN_IP:   own_ip   <= pwdata[IP_W-1:0];
        REG_LIFETIME: lifetime <= pwdata[TTL_W-1:0];
        REG_HOLDOFF:  holdoff  <= pwdata[TTL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_OWN_MAC:  prdata = {16'd0, own_mac};
      REG_OWN_IP:   prdata = {32'd0, own_ip};
      REG_LIFETIME: prdata = {40'd0, lifetime};
      REG_HOLDOFF:  prdata = {40'd0, holdoff};
      default:      prdata = '0;
    endcase
  end

  // ---------------- tables ----------------
  logic [IP_W-1:0] cmp_key;
  assign cmp_key = (item.command == CMD_SEND) ? item.hop_ip : item.arp_sender_ip;

  ttl_ctrl_t        c_ctrl [CACHE_ENTRIES];
  logic             c_valid [CACHE_ENTRIES];
  logic             c_match [CACHE_ENTRIES];
  logic [TTL_W-1:0] c_ttl [CACHE_ENTRIES];
  logic [MAC_W-1:0] c_mac [CACHE_ENTRIES];

  ttl_ctrl_t        p_ctrl [PENDING_ENTRIES];
  logic             p_valid [PENDING_ENTRIES];
  logic             p_match [PENDING_ENTRIES];
  logic [TTL_W-1:0] p_ttl [PENDING_ENTRIES];

  logic [IP_W-1:0]  w_ip [WAIT_ENTRIES];
  logic [ID_W-1:0]  w_hdl [WAIT_ENTRIES];
  logic             w_match [WAIT_ENTRIES];
  wait_ctrl_t       w_ctrl [WAIT_ENTRIES];

  logic c_wr, c_age, p_wr, p_clr, p_age, w_push, w_shift;

  for (genvar j = 0; j < CACHE_ENTRIES; j++) begin : g_cache
    assign c_ctrl[j] = '{wr:  c_wr && (slot[CW-1:0] == CW'(j)),
                         clr: 1'b0,
                         age: c_age};
    are_ttl_cell u_cell (
      .clk(clk), .rst(rst), .ctrl(c_ctrl[j]),
      .key_in(item.arp_sender_ip), .ttl_in(lifetime),
      .cmp_key(cmp_key), .elapsed(item.elapsed_ms),
      .valid(c_valid[j]), .match(c_match[j]), .ttl(c_ttl[j])
    );
  end

  always_ff @(posedge clk) begin
    if (c_wr) begin
      c_mac[slot[CW-1:0]] <= item.arp_sender_mac;
    end
  end

  for (genvar j = 0; j < PENDING_ENTRIES; j++) begin : g_pend
    assign p_ctrl[j] = '{wr:  p_wr && (slot[PW-1:0] == PW'(j)),
                         clr: p_clr,
                         age: p_age};
    are_ttl_cell u_cell (
      .clk(clk), .rst(rst), .ctrl(p_ctrl[j]),
      .key_in(item.hop_ip), .ttl_in(holdoff),
      .cmp_key(cmp_key), .elapsed(item.elapsed_ms),
      .valid(p_valid[j]), .match(p_match[j]), .ttl(p_ttl[j])
    );
  end

  for (genvar j = 0; j < WAIT_ENTRIES; j++) begin : g_wait
    assign w_ctrl[j] = '{load:      w_push && (wait_count == NW'(j)),
                         shift:     w_shift && (NW'(j) < wait_count),
                         take_head: wait_count == NW'(j + 1)};
    are_wait_cell u_cell (
      .clk(clk), .ctrl(w_ctrl[j]),
      .push_ip(item.hop_ip), .push_hdl(item.datagram_id),
      .next_ip(w_ip[(j + 1) % WAIT_ENTRIES]), .next_hdl(w_hdl[(j + 1) % WAIT_ENTRIES]),
      .head_ip(w_ip[0]), .head_hdl(w_hdl[0]),
      .cmp_key(cmp_key),
      .ip(w_ip[j]), .hdl(w_hdl[j]), .match(w_match[j])
    );
  end

  // ---------------- lookups ----------------
  logic          c_hit, c_free_any, p_hit, p_free_any;
  logic [CW-1:0] c_hit_idx, c_free_idx;
  logic [PW-1:0] p_free_idx;
  logic [NW-1:0] w_hits;

  always_comb begin
    c_hit = 1'b0; c_free_any = 1'b0; c_hit_idx = '0; c_free_idx = '0;
    for (int j = CACHE_ENTRIES - 1; j >= 0; j--) begin
      if (c_match[j]) begin
        c_hit = 1'b1; c_hit_idx = CW'(j);
      end
      if (!c_valid[j]) begin
        c_free_any = 1'b1; c_free_idx = CW'(j);
      end
    end
  end

  always_comb begin
    p_hit = 1'b0; p_free_any = 1'b0; p_free_idx = '0;
    for (int j = PENDING_ENTRIES - 1; j >= 0; j--) begin
      if (p_match[j]) p_hit = 1'b1;
      if (!p_valid[j]) begin
        p_free_any = 1'b1; p_free_idx = PW'(j);
      end
    end
  end

  always_comb begin
    w_hits = '0;
    for (int j = 0; j < WAIT_ENTRIES; j++) begin
      if (w_match[j] && (NW'(j) < wait_count)) w_hits = w_hits + NW'(1);
    end
  end

  logic [TTL_W-1:0] scan_ttl;
  logic             scan_take, scan_done;
  assign scan_ttl  = scan_cache ? c_ttl[scan_idx[CW-1:0]] : p_ttl[scan_idx[PW-1:0]];
  assign scan_take = (scan_idx == '0) || (scan_ttl < best_ttl);
  assign scan_done = scan_cache ? (scan_idx == SW'(CACHE_ENTRIES - 1))
                                : (scan_idx == SW'(PENDING_ENTRIES - 1));

  // ---------------- sequencer ----------------
  logic      can_emit, emit;
  out_item_t emit_item;
  logic      ours, wait_full, head_hit;

  assign can_emit  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);
  assign ours      = (item.frame_dst_mac == own_mac) ||
                     (item.frame_dst_mac == MAC_BCAST);
  assign wait_full = (wait_count == NW'(WAIT_ENTRIES));
  assign head_hit  = w_match[0];

  always_comb begin
    emit = 1'b0; emit_item = '0;
    c_wr = 1'b0; c_age = 1'b0;
    p_wr = 1'b0; p_clr = 1'b0; p_age = 1'b0;
    w_push = 1'b0; w_shift = 1'b0;
    unique case (state)
      S_SEND: begin
        if (can_emit) begin
          if (c_hit) begin
            emit = 1'b1;
            emit_item = '{KIND_IPV4, c_mac[c_hit_idx], item.datagram_id, '0, '0, 1'b1};
          end else if (wait_full) begin
            emit = 1'b1;
            emit_item = '{KIND_DROPPED, '0, item.datagram_id, '0, '0, p_hit};
          end else begin
            w_push = 1'b1;
          end
        end
      end
      S_PREQ: begin
        if (can_emit) begin
          emit = 1'b1; p_wr = 1'b1;
          emit_item = '{KIND_REQUEST, MAC_BCAST, '0, item.hop_ip, '0, 1'b1};
        end
      end
      S_RX: begin
        if (ours && item.frame_ether_type == ETH_IPV4 && item.payload_ok && can_emit) begin
          emit = 1'b1;
          emit_item = '{KIND_DELIVER, '0, item.datagram_id, '0, '0, 1'b1};
        end
      end
      S_LEARN: begin
        c_wr = 1'b1; p_clr = 1'b1;
      end
      S_FLUSH: begin
        if (iter != '0) begin
          if (!head_hit) begin
            w_shift = 1'b1;
          end else if (can_emit) begin
            w_shift = 1'b1; emit = 1'b1;
            emit_item = '{KIND_IPV4, item.arp_sender_mac, w_hdl[0], '0, '0,
                          (match_cnt == NW'(1)) && !reply};
          end
        end
      end
      S_REPLY: begin
        if (can_emit) begin
          emit = 1'b1;
          emit_item = '{KIND_REPLY, item.arp_sender_mac, '0, item.arp_sender_ip,
                        item.arp_sender_mac, 1'b1};
        end
      end
      S_TICK: begin
        c_age = 1'b1; p_age = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      wait_count <= '0;
      scan_cache <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            unique case (in_data.command)
              CMD_SEND: state <= S_SEND;
              CMD_RECV: state <= S_RX;
              CMD_TICK: state <= S_TICK;
              default:  state <= S_IDLE;
            endcase
          end
        end
        S_SEND: begin
          if (can_emit) begin
            if (w_push) wait_count <= wait_count + NW'(1);
            if (c_hit || p_hit) begin
              state <= S_IDLE;
            end else if (p_free_any) begin
              slot  <= SW'(p_free_idx);
              state <= S_PREQ;
            end else begin
              scan_cache <= 1'b0; scan_idx <= '0;
              state <= S_SCAN;
            end
          end
        end
        S_PREQ: if (can_emit) state <= S_IDLE;
        S_RX: begin
          if (!ours || !item.payload_ok || item.frame_ether_type != ETH_ARP) begin
            if (!ours || item.frame_ether_type != ETH_IPV4 || !item.payload_ok || can_emit)
              state <= S_IDLE;
          end else if (c_hit) begin
            slot <= SW'(c_hit_idx); state <= S_LEARN;
          end else if (c_free_any) begin
            slot <= SW'(c_free_idx); state <= S_LEARN;
          end else begin
            scan_cache <= 1'b1; scan_idx <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_take) begin
            best_ttl <= scan_ttl; best_idx <= scan_idx;
          end
          if (scan_done) begin
            slot  <= scan_take ? scan_idx : best_idx;
            state <= scan_cache ? S_LEARN : S_PREQ;
          end else begin
            scan_idx <= scan_idx + SW'(1);
          end
        end
        S_LEARN: begin
          iter      <= wait_count;
          match_cnt <= w_hits;
          reply     <= (item.arp_opcode == ARP_OP_REQUEST) && (item.arp_target_ip == own_ip);
          state     <= S_FLUSH;
        end
        S_FLUSH: begin
          if (iter == '0) begin
            state <= reply ? S_REPLY : S_IDLE;
          end else if (w_shift) begin
            iter <= iter - NW'(1);
            if (head_hit) begin
              // drop the flushed datagram from the live chain
              wait_count <= wait_count - NW'(1);
              match_cnt  <= match_cnt - NW'(1);
            end
          end
        end
        S_REPLY: if (can_emit) state <= S_IDLE;
        S_TICK:  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) item <= in_data;
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_data <= emit_item;
  end

`ifndef ASSERT_OFF
  a_wait_bound: assert property (@(posedge clk) disable iff (rst)
    wait_count <= NW'(WAIT_ENTRIES))
    else $error("wait count beyond depth");

  a_flush_all: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH && iter == '0) |-> match_cnt == '0)
    else $error("flush ended with parked matches left");

  a_scan_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && !scan_cache) |-> !p_free_any)
    else $error("pending scan with a free slot");

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    emit |-> can_emit)
    else $error("result overwrote a waiting beat");
`endif

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for arp_resolution_engine: drives send, receive and
// tick beats plus APB register writes, predicts every outgoing beat from a
// behavioral copy of the cache, pending and wait tables, and compares each
// accepted output beat with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import are_pkg::*;

  localparam logic [15:0] ARP_OP_REPLY = 16'd2;
  localparam logic [1:0]  CMD_UNKNOWN  = 2'd3;
  localparam int CACHE_N  = 16;
  localparam int PEND_N   = 8;
  localparam int WAIT_N   = 16;
  localparam int DRAIN_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  arp_resolution_engine dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [MAC_W-1:0] m_own_mac;
  logic [IP_W-1:0]  m_own_ip;
  logic [TTL_W-1:0] m_lifetime;
  logic [TTL_W-1:0] m_holdoff;
  logic [IP_W-1:0]  c_ip [CACHE_N];
  logic [MAC_W-1:0] c_mac [CACHE_N];
  logic [TTL_W-1:0] c_ttl [CACHE_N];
  bit               c_v [CACHE_N];
  logic [IP_W-1:0]  p_ip [CACHE_N];
  logic [TTL_W-1:0] p_ttl [CACHE_N];
  bit               p_v [CACHE_N];
  logic [IP_W-1:0]  w_ip [WAIT_N];
  logic [ID_W-1:0]  w_id [WAIT_N];
  int               w_cnt;

  out_item_t expected_frames[$];
  int  errors = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_cnt = 0;
  int  burst = 0;
  logic [IP_W-1:0] ip_pool [6];

  // Own entry for the key, else lowest free, else smallest ttl (lowest index on ties).
  function automatic int pick_slot(bit v[CACHE_N], logic [IP_W-1:0] k[CACHE_N],
                                   logic [TTL_W-1:0] t[CACHE_N], int depth,
                                   logic [IP_W-1:0] key);
    int victim;
    victim = 0;
    for (int i = 0; i < depth; i++) if (v[i] && k[i] == key) return i;
    for (int i = 0; i < depth; i++) if (!v[i]) return i;
    for (int i = 1; i < depth; i++) if (t[i] < t[victim]) victim = i;
    return victim;
  endfunction

  function automatic out_item_t beat(logic [2:0] kind, logic [MAC_W-1:0] dst,
                                     logic [ID_W-1:0] id, logic [IP_W-1:0] tip,
                                     logic [MAC_W-1:0] tmac);
    out_item_t o;
    o = '0;
    o.kind = kind;
    o.dst_mac = dst;
    o.out_datagram_id = id;
    o.arp_target_ip_out = tip;
    o.arp_target_mac_out = tmac;
    return o;
  endfunction

  function automatic void arp_predict(in_item_t it);
    out_item_t r[$];
    out_item_t tmp;
    bit pend;
    bit hit;
    int s;
    int k;
    pend = 0;
    hit = 0;
    case (it.command)
      CMD_SEND: begin
        for (int i = 0; i < CACHE_N; i++)
          if (!hit && c_v[i] && c_ip[i] == it.hop_ip) begin
            r = {r, beat(KIND_IPV4, c_mac[i], it.datagram_id, '0, '0)};
            hit = 1;
          end
        if (!hit) begin
          if (w_cnt < WAIT_N) begin
            w_ip[w_cnt] = it.hop_ip;
            w_id[w_cnt] = it.datagram_id;
            w_cnt++;
          end else begin
            r = {r, beat(KIND_DROPPED, '0, it.datagram_id, '0, '0)};
          end
          for (int i = 0; i < PEND_N; i++)
            if (p_v[i] && p_ip[i] == it.hop_ip) pend = 1;
          if (!pend) begin
            s = pick_slot(p_v, p_ip, p_ttl, PEND_N, it.hop_ip);
            r = {r, beat(KIND_REQUEST, MAC_BCAST, '0, it.hop_ip, '0)};
            p_ip[s] = it.hop_ip;
            p_ttl[s] = m_holdoff;
            p_v[s] = 1;
          end
        end
      end
      CMD_RECV: begin
        if (it.frame_dst_mac == m_own_mac || it.frame_dst_mac == MAC_BCAST) begin
          if (it.frame_ether_type == ETH_IPV4) begin
            if (it.payload_ok) r = {r, beat(KIND_DELIVER, '0, it.datagram_id, '0, '0)};
          end else if (it.frame_ether_type == ETH_ARP && it.payload_ok) begin
            s = pick_slot(c_v, c_ip, c_ttl, CACHE_N, it.arp_sender_ip);
            c_ip[s] = it.arp_sender_ip;
            c_mac[s] = it.arp_sender_mac;
            c_ttl[s] = m_lifetime;
            c_v[s] = 1;
            for (int i = 0; i < PEND_N; i++)
              if (p_v[i] && p_ip[i] == it.arp_sender_ip) p_v[i] = 0;
            k = 0;
            for (int i = 0; i < w_cnt; i++) begin
              if (w_ip[i] == it.arp_sender_ip) begin
                r = {r, beat(KIND_IPV4, it.arp_sender_mac, w_id[i], '0, '0)};
              end else begin
                w_ip[k] = w_ip[i];
                w_id[k] = w_id[i];
                k++;
              end
            end
            w_cnt = k;
            if (it.arp_opcode == ARP_OP_REQUEST && it.arp_target_ip == m_own_ip)
              r = {r, beat(KIND_REPLY, it.arp_sender_mac, '0, it.arp_sender_ip,
                           it.arp_sender_mac)};
          end
        end
      end
      CMD_TICK: begin
        for (int i = 0; i < CACHE_N; i++)
          if (c_v[i]) begin
            if (c_ttl[i] <= it.elapsed_ms) c_v[i] = 0;
            else c_ttl[i] = c_ttl[i] - it.elapsed_ms;
          end
        for (int i = 0; i < PEND_N; i++)
          if (p_v[i]) begin
            if (p_ttl[i] <= it.elapsed_ms) p_v[i] = 0;
            else p_ttl[i] = p_ttl[i] - it.elapsed_ms;
          end
      end
      default: ;
    endcase
    if (r.size() > 0) begin
      tmp = r[r.size()-1];
      tmp.last = 1'b1;
      r[r.size()-1] = tmp;
    end
    foreach (r[i]) expected_frames = {expected_frames, r[i]};
  endfunction

  // Offer one beat, at times with a random gap ahead of it (none when quiet); valid stays high afterwards.
  task automatic send_item(in_item_t it);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    arp_predict(it);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    wait (expected_frames.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_OWN_MAC:  m_own_mac = value[MAC_W-1:0];
      REG_OWN_IP:   m_own_ip = value[IP_W-1:0];
      REG_LIFETIME: m_lifetime = value[TTL_W-1:0];
      default:      m_holdoff = value[TTL_W-1:0];
    endcase
  endtask

  task automatic set_config(logic [MAC_W-1:0] mac, logic [IP_W-1:0] ip,
                            logic [TTL_W-1:0] life, logic [TTL_W-1:0] hold);
    wait_idle();
    cfg_write(REG_OWN_MAC, 64'(mac));
    cfg_write(REG_OWN_IP, 64'(ip));
    cfg_write(REG_LIFETIME, 64'(life));
    cfg_write(REG_HOLDOFF, 64'(hold));
  endtask

  function automatic logic [MAC_W-1:0] rand_mac();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic in_item_t mk_send(logic [IP_W-1:0] ip, logic [ID_W-1:0] id);
    in_item_t it;
    it = '0;
    it.command = CMD_SEND;
    it.hop_ip = ip;
    it.datagram_id = id;
    return it;
  endfunction

  function automatic in_item_t mk_arp(logic [MAC_W-1:0] dst, logic [15:0] op,
                                      logic [IP_W-1:0] sip, logic [MAC_W-1:0] smac,
                                      logic [IP_W-1:0] tip);
    in_item_t it;
    it = '0;
    it.command = CMD_RECV;
    it.frame_dst_mac = dst;
    it.frame_ether_type = ETH_ARP;
    it.payload_ok = 1'b1;
    it.arp_opcode = op;
    it.arp_sender_ip = sip;
    it.arp_sender_mac = smac;
    it.arp_target_ip = tip;
    it.datagram_id = 16'($urandom());
    return it;
  endfunction

  function automatic in_item_t mk_ipv4(logic [MAC_W-1:0] dst, logic [ID_W-1:0] id,
                                       logic ok, logic [15:0] etype);
    in_item_t it;
    it = '0;
    it.command = CMD_RECV;
    it.frame_dst_mac = dst;
    it.frame_ether_type = etype;
    it.payload_ok = ok;
    it.datagram_id = id;
    return it;
  endfunction

  function automatic in_item_t mk_tick(logic [TTL_W-1:0] el);
    in_item_t it;
    it = '0;
    it.command = CMD_TICK;
    it.elapsed_ms = el;
    return it;
  endfunction

  function automatic in_item_t mk_noise();
    in_item_t it;
    it.command = 2'($urandom_range(0, 3));
    it.hop_ip = $urandom();
    it.datagram_id = 16'($urandom());
    it.frame_dst_mac = rand_mac();
    it.frame_ether_type = 16'($urandom());
    it.payload_ok = 1'($urandom());
    it.arp_opcode = 16'($urandom());
    it.arp_sender_ip = $urandom();
    it.arp_sender_mac = rand_mac();
    it.arp_target_ip = $urandom();
    it.elapsed_ms = 24'($urandom());
    return it;
  endfunction

  function automatic in_item_t mk_random();
    in_item_t it;
    logic [MAC_W-1:0] dst;
    int sel;
    sel = $urandom_range(0, 99);
    dst = $urandom_range(0, 1) ? m_own_mac : MAC_BCAST;
    if (sel < 35) it = mk_send(ip_pool[$urandom_range(0, 5)], 16'($urandom()));
    else if (sel < 60)
      it = mk_arp(dst, $urandom_range(0, 3) == 0 ? ARP_OP_REPLY : ARP_OP_REQUEST,
                  ip_pool[$urandom_range(0, 5)], rand_mac(),
                  $urandom_range(0, 1) ? m_own_ip : $urandom());
    else if (sel < 70) it = mk_tick(24'($urandom_range(0, 60)));
    else if (sel < 80)
      it = mk_ipv4(dst, 16'($urandom()), $urandom_range(0, 4) != 0, ETH_IPV4);
    else it = mk_noise();
    return it;
  endfunction

  // Output side: compare each accepted beat, idle in bursts, honor long hold-offs.
  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_frames.size() == 0) begin
          $display("%0t: unexpected beat %p", $time, out_data);
          errors++;
        end else begin
          e = expected_frames.pop_front();
          if (e.kind != out_data.kind || e.dst_mac != out_data.dst_mac ||
              e.out_datagram_id != out_data.out_datagram_id ||
              e.arp_target_ip_out != out_data.arp_target_ip_out ||
              e.arp_target_mac_out != out_data.arp_target_mac_out ||
              e.last != out_data.last) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, out_data);
            errors++;
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_cnt <= 400;
        out_stall <= 1'b1;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_stall <= (hold_cnt > 1);
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else if (burst > 0) begin
        burst <= burst - 1;
      end else begin
        burst <= $urandom_range(1, 16);
        out_stall <= ($urandom_range(0, 2) == 0);
      end
    end
  end

  // Watchdog: count cycles in which no beat moves on either channel and psel is low.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic test_reset_defaults();
    // own_mac is zero after reset, so a zero destination is ours
    send_item(mk_send(32'h0a00_0001, 16'h0001));
    send_item(mk_arp(48'h0, ARP_OP_REQUEST, 32'h0a00_0001, 48'h0200_0000_0001, 32'h0));
    send_item(mk_send(32'h0a00_0001, 16'h0002));
  endtask

  task automatic test_directed();
    set_config(48'h0200_0000_00aa, 32'hc0a8_0001, 24'd1000, 24'd100);
    send_item(mk_send(32'hc0a8_0002, 16'h0000));
    send_item(mk_send(32'hc0a8_0002, 16'hffff));  // already pending: no request
    send_item(mk_send(32'hc0a8_0003, 16'h1234));
    send_item(mk_arp(48'h0200_0000_00aa, ARP_OP_REPLY, 32'hc0a8_0002,
                     48'hffff_ffff_fffe, 32'h0));
    send_item(mk_send(32'hc0a8_0002, 16'h0042));  // hit
    send_item(mk_arp(MAC_BCAST, ARP_OP_REQUEST, 32'hc0a8_0003,
                     48'h0000_0000_0001, 32'hc0a8_0001));
    send_item(mk_arp(MAC_BCAST, 16'hffff, 32'hc0a8_0004, 48'h0, 32'hc0a8_0001));
    send_item(mk_ipv4(48'h0200_0000_00aa, 16'hbeef, 1'b1, ETH_IPV4));
    send_item(mk_ipv4(MAC_BCAST, 16'hbeef, 1'b0, ETH_IPV4));
    send_item(mk_ipv4(48'h0200_0000_00ab, 16'h0007, 1'b1, ETH_IPV4));  // not ours
    send_item(mk_ipv4(MAC_BCAST, 16'h0008, 1'b1, 16'h86dd));  // other ethertype
    send_item(mk_arp(48'h0200_0000_00aa, ARP_OP_REQUEST, 32'hc0a8_0005,
                     48'h1, 32'h0) ^ in_item_t'(0));
    begin
      in_item_t it;
      it = mk_arp(MAC_BCAST, ARP_OP_REQUEST, 32'hc0a8_0006, 48'h2, 32'hc0a8_0001);
      it.payload_ok = 1'b0;
      send_item(it);
      it = mk_noise();
      it.command = CMD_UNKNOWN;
      send_item(it);
    end
    send_item(mk_tick(24'd0));
    send_item(mk_tick(24'd999));
    send_item(mk_send(32'hc0a8_0002, 16'h0050));
    send_item(mk_tick(24'd1));  // cache entries reach zero
    send_item(mk_send(32'hc0a8_0002, 16'h0051));
    send_item(mk_tick(24'hffffff));
  endtask

  task automatic test_wait_full();
    set_config(rand_mac(), 32'h0a0a_0a0a, 24'd5000, 24'd5000);
    for (int i = 0; i < WAIT_N + 2; i++) send_item(mk_send(32'h0a0a_0001, 16'(i)));
    send_item(mk_send(32'h0a0a_0002, 16'h7777));  // full store, request still sent
    send_item(mk_arp(MAC_BCAST, ARP_OP_REQUEST, 32'h0a0a_0001,
                     48'h0a0a_0a0a_0a01, 32'h0a0a_0a0a));
  endtask

  task automatic test_tables_full();
    set_config(48'hffff_ffff_ffff, 32'hffff_ffff, 24'hffffff, 24'd1);
    for (int i = 0; i < CACHE_N + 3; i++) begin
      send_item(mk_arp(MAC_BCAST, ARP_OP_REPLY, 32'h1000_0000 + i, 48'(i + 1), '0));
      if (i % 4 == 0) send_item(mk_tick(24'd3));
    end
    for (int i = 0; i < PEND_N + 3; i++) begin
      send_item(mk_send(32'h2000_0000 + i, 16'(i)));
      if (i % 3 == 0) send_item(mk_tick(24'd0));
    end
    send_item(mk_tick(24'd1));
    set_config(48'h0, 32'h0, 24'd1, 24'hffffff);
    send_item(mk_arp(48'h0, ARP_OP_REQUEST, 32'h3000_0001, 48'h5, 32'h0));
    send_item(mk_send(32'h3000_0001, 16'h0001));
    send_item(mk_tick(24'd1));
    send_item(mk_send(32'h3000_0001, 16'h0002));
    send_item(mk_send(32'h3000_0001, 16'h0003));
  endtask

  task automatic test_backpressure();
    set_config(48'h0200_0000_0001, 32'h0a00_0001, 24'd200, 24'd50);
    hold_req = 1'b1;
    for (int i = 0; i < 24; i++) send_item(mk_ipv4(MAC_BCAST, 16'(i), 1'b1, ETH_IPV4));
  endtask

  task automatic test_random();
    for (int i = 0; i < 6; i++) ip_pool[i] = 32'h0a00_0010 + i;
    for (int i = 0; i < 58; i++) begin
      if (i == 44) quiet = 1'b1;
      send_item(mk_random());
    end
  endtask

  initial begin
    m_own_mac = '0;
    m_own_ip = '0;
    m_lifetime = LIFETIME_RESET;
    m_holdoff = HOLDOFF_RESET;
    w_cnt = 0;
    foreach (c_v[i]) begin
      c_v[i] = 0;
      p_v[i] = 0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_directed();
    test_wait_full();
    test_tables_full();
    test_backpressure();
    test_random();
    wait_idle();
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/are_pkg.sv
rtl/are_ttl_cell.sv
rtl/are_wait_cell.sv
rtl/arp_resolution_engine.sv
bench/tb_top.sv
